/* src/wacl_pkg.sv */
// ----------------------------------------------------------------------------
// wacl_pkg
// Shared types, request codes and digit-mask helpers for the ACL packet filter.
// ----------------------------------------------------------------------------
package wacl_pkg;

    localparam int ADDR_W   = 32;
    localparam int WILD_W   = 8;
    localparam int IDX_OUT_W = 6;
    localparam int DIG_W    = 4;
    localparam int REQ_W    = 2;
    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 16;

    localparam logic [REQ_W-1:0] REQ_APPEND   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_CLASSIFY = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR    = 2'd2;

    typedef struct packed {
        logic [ADDR_W-1:0] src_val;
        logic [WILD_W-1:0] src_care;
        logic [ADDR_W-1:0] dst_val;
        logic [WILD_W-1:0] dst_care;
        logic              allow;
    } t_rule;

    typedef struct packed {
        logic                 vld;
        logic [ADDR_W-1:0]    src;
        logic [ADDR_W-1:0]    dst;
        logic                 hit;
        logic                 allow;
        logic [IDX_OUT_W-1:0] idx;
    } t_token;

    // digits that must match: inside the address width and not wildcarded
    function automatic logic [WILD_W-1:0] care_bits(input logic [WILD_W-1:0] wild,
                                                    input int digits);
        logic [WILD_W-1:0] c;
        c = '0;
        for (int i = 0; i < WILD_W; i++) begin
            c[i] = (i < digits) && !wild[i];
        end
        return c;
    endfunction

    function automatic logic [ADDR_W-1:0] expand_care(input logic [WILD_W-1:0] care);
        logic [ADDR_W-1:0] m;
        m = '0;
        for (int i = 0; i < WILD_W; i++) begin
            m[i*DIG_W +: DIG_W] = {DIG_W{care[i]}};
        end
        return m;
    endfunction

endpackage

/* src/wacl_cell.sv */
// ----------------------------------------------------------------------------
// wacl_cell
// One rule slot; compares the passing search token and hands it on.
// ----------------------------------------------------------------------------
module wacl_cell
    import wacl_pkg::*;
#(
    parameter int CELL_IDX = 0
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_wr,
    input  logic   i_clr,
    input  t_rule  i_rule,
    input  t_token i_tok,
    output t_token o_tok
);

    logic   r_vld;
    t_rule  r_rule;
    t_token r_tok;
    t_token n_tok;
    logic   w_hit;

    assign w_hit = r_vld
        && ((i_tok.src & expand_care(r_rule.src_care)) == r_rule.src_val)
        && ((i_tok.dst & expand_care(r_rule.dst_care)) == r_rule.dst_val);

    // later cells hold newer rules, so a later hit overrides
    always_comb begin
        n_tok = i_tok;
        if (i_tok.vld && w_hit) begin
            n_tok.hit   = 1'b1;
            n_tok.allow = r_rule.allow;
            n_tok.idx   = IDX_OUT_W'(CELL_IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_tok <= '0;
        end else begin
            r_tok <= n_tok;
            if (i_clr) begin
                r_vld <= 1'b0;
            end else if (i_wr) begin
                r_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_rule <= i_rule;
        end
    end

    assign o_tok = r_tok;

endmodule

/* src/wildcard_acl_packet_filter.sv */
// ----------------------------------------------------------------------------
// wildcard_acl_packet_filter
// Last-match permit/deny filter over a table of wildcard digit rules.
// ----------------------------------------------------------------------------
// Rules live in a row of MAX_RULES cells, one rule per cell. An append or a
// clear takes effect at once and its result beat appears the cycle after it is
// accepted. A classify beat launches a search token that steps through one cell
// per cycle, down the whole row and then into the result register. One request
// is in flight at a time: a new beat is taken once no search is running and the
// result register is free or being drained in the same cycle.
module wildcard_acl_packet_filter
    import wacl_pkg::*;
#(
    parameter int MAX_RULES   = 64,
    parameter int ADDR_DIGITS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // [31:0] src_addr, [39:32] src_wild, [71:40] dst_addr, [79:72] dst_wild,
    // [80] rule_permits, [87:81] zero
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // [1:0] req_type
    input  logic [REQ_W-1:0]      i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [0] permitted, [1] matched, [7:2] match_index, [8] status, [15:9] zero
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    localparam int CNT_W = $clog2(MAX_RULES + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_SRCH = 1'b1;

    logic                 r_state;
    logic [CNT_W-1:0]     r_count;
    logic                 r_out_vld;
    logic [OUT_DATA_W-1:0] r_out_data;

    logic                 w_acc;
    logic                 w_full;
    logic                 w_wr;
    logic [ADDR_W-1:0]    w_src;
    logic [ADDR_W-1:0]    w_dst;
    logic [WILD_W-1:0]    w_src_care;
    logic [WILD_W-1:0]    w_dst_care;
    t_rule                w_rule;
    t_token               w_tok [MAX_RULES+1];
    t_token               w_done;

    assign w_src      = i_s_axis_tdata[31:0];
    assign w_dst      = i_s_axis_tdata[71:40];
    assign w_src_care = care_bits(i_s_axis_tdata[39:32], ADDR_DIGITS);
    assign w_dst_care = care_bits(i_s_axis_tdata[79:72], ADDR_DIGITS);

    assign o_s_axis_tready = (r_state == ST_IDLE) && (!r_out_vld || i_m_axis_tready);
    assign w_acc  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_full = (r_count >= CNT_W'(MAX_RULES));
    assign w_wr   = w_acc && (i_s_axis_tuser == REQ_APPEND) && !w_full;

    always_comb begin
        w_rule.src_val  = w_src & expand_care(w_src_care);
        w_rule.src_care = w_src_care;
        w_rule.dst_val  = w_dst & expand_care(w_dst_care);
        w_rule.dst_care = w_dst_care;
        w_rule.allow    = i_s_axis_tdata[80];
    end

    always_comb begin
        w_tok[0]     = '0;
        w_tok[0].vld = w_acc && (i_s_axis_tuser == REQ_CLASSIFY);
        w_tok[0].src = w_src;
        w_tok[0].dst = w_dst;
    end

    for (genvar k = 0; k < MAX_RULES; k++) begin : g_cell
        wacl_cell #(
            .CELL_IDX (k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_wr    (w_wr && (r_count == CNT_W'(k))),
            .i_clr   (w_acc && (i_s_axis_tuser == REQ_CLEAR)),
            .i_rule  (w_rule),
            .i_tok   (w_tok[k]),
            .o_tok   (w_tok[k+1])
        );
    end

    assign w_done = w_tok[MAX_RULES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (w_wr) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_acc && (i_s_axis_tuser == REQ_CLEAR)) begin
                r_count <= '0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (w_acc && (i_s_axis_tuser == REQ_CLASSIFY)) begin
                        r_state <= ST_SRCH;
                    end
                end
                ST_SRCH: begin
                    if (w_done.vld) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase

            if ((w_acc && (i_s_axis_tuser != REQ_CLASSIFY)) || w_done.vld) begin
                r_out_vld <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done.vld) begin
            r_out_data <= {7'd0, 1'b0, w_done.idx, w_done.hit, w_done.hit && w_done.allow};
        end else if (w_acc && (i_s_axis_tuser != REQ_CLASSIFY)) begin
            r_out_data <= {7'd0, (i_s_axis_tuser == REQ_APPEND) && w_full,
                           {IDX_OUT_W{1'b0}}, 1'b0, 1'b0};
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_data;

endmodule

/* src/wacl_chk.sv */
// ----------------------------------------------------------------------------
// wacl_chk
// Port-level checks for the ACL packet filter, bound to the top level.
// ----------------------------------------------------------------------------
module wacl_chk
    import wacl_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_axis_tvalid,
    input logic                  o_s_axis_tready,
    input logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    input logic [REQ_W-1:0]      i_s_axis_tuser,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    a_rst_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result beat out of reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result beat changed");

    a_nomatch_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tdata[1] |-> !o_m_axis_tdata[0]
            && (o_m_axis_tdata[7:2] == '0))
        else $error("permit or index without a match");

    a_status_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[8] |-> !o_m_axis_tdata[1])
        else $error("full status on a classify result");

    a_quick_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready && (i_s_axis_tuser != REQ_CLASSIFY)
            |=> o_m_axis_tvalid)
        else $error("append or clear result late");

endmodule

bind wildcard_acl_packet_filter wacl_chk u_wacl_chk (.*);

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the wildcard ACL packet filter. A queue of request
// beats (append, classify, clear and the spare code) is built at time zero:
// a short directed run over the corner cases, then random rule sets with
// classify beats mostly aimed at stored rules. A driver feeds the slave side,
// a monitor takes each accepted beat through a last-match rule table model
// and checks every result beat in order. Idling and back-pressure vary by
// phase.
// ----------------------------------------------------------------------------
module tb
    import wacl_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int               MAX_RULES  = 64;
    localparam int               N_ITEMS    = 1320;
    localparam int               TAIL_CYC   = 100;
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct {
        logic [REQ_W-1:0]  kind;
        logic [ADDR_W-1:0] src;
        logic [WILD_W-1:0] swild;
        logic [ADDR_W-1:0] dst;
        logic [WILD_W-1:0] dwild;
        logic              allow;
        int                idle_pct;
        int                stall_pct;
        bit                drain;
    } t_req;

    typedef struct {
        logic           permitted;
        logic           matched;
        logic [5:0]     index;
        logic           status;
    } t_verdict;

    logic                  i_clk;
    logic                  i_rst_n          = 1'b0;
    logic                  i_s_axis_tvalid  = 1'b0;
    logic                  o_s_axis_tready;
    logic [IN_DATA_W-1:0]  i_s_axis_tdata   = '0;
    logic [REQ_W-1:0]      i_s_axis_tuser   = '0;
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready  = 1'b0;
    logic [OUT_DATA_W-1:0] o_m_axis_tdata;

    wildcard_acl_packet_filter #(
        .MAX_RULES   (MAX_RULES),
        .ADDR_DIGITS (8)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    t_req     pend_q[$];
    t_verdict verdict_q[$];
    t_req     on_bus;
    logic     beat_taken = 1'b0;
    int       rx_stall_pct = 0;

    // rule table model
    logic [ADDR_W-1:0] tbl_src[MAX_RULES];
    logic [WILD_W-1:0] tbl_swild[MAX_RULES];
    logic [ADDR_W-1:0] tbl_dst[MAX_RULES];
    logic [WILD_W-1:0] tbl_dwild[MAX_RULES];
    logic              tbl_allow[MAX_RULES];
    int                rule_cnt = 0;

    // generator-side copy, used to aim classify beats at stored rules
    logic [ADDR_W-1:0] gen_src[MAX_RULES];
    logic [WILD_W-1:0] gen_swild[MAX_RULES];
    logic [ADDR_W-1:0] gen_dst[MAX_RULES];
    logic [WILD_W-1:0] gen_dwild[MAX_RULES];
    int                gen_cnt = 0;
    bit                drain_next = 0;

    int n_items = 0;
    int n_taken = 0;
    int n_class = 0;
    int n_hit   = 0;
    int n_full  = 0;
    int n_spare = 0;
    int n_err   = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin
        #10ms;
        $display("Timeout at %0t ns", $time);
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [ADDR_W-1:0] digit_mask(input logic [WILD_W-1:0] wild);
        logic [ADDR_W-1:0] m;
        m = '0;
        for (int d = 0; d < WILD_W; d++) begin
            if (!wild[d]) m[d*DIG_W +: DIG_W] = 4'hF;
        end
        return m;
    endfunction

    task automatic predict_verdict(input t_req r);
        t_verdict v;
        int       k;
        v = '{default: '0};
        case (r.kind)
            REQ_APPEND: begin
                if (rule_cnt >= MAX_RULES) begin
                    v.status = 1'b1;
                    n_full++;
                end else begin
                    tbl_src[rule_cnt]   = r.src & digit_mask(r.swild);
                    tbl_swild[rule_cnt] = r.swild;
                    tbl_dst[rule_cnt]   = r.dst & digit_mask(r.dwild);
                    tbl_dwild[rule_cnt] = r.dwild;
                    tbl_allow[rule_cnt] = r.allow;
                    rule_cnt++;
                end
            end
            REQ_CLASSIFY: begin
                n_class++;
                for (k = rule_cnt - 1; k >= 0; k--) begin
                    if ((r.src & digit_mask(tbl_swild[k])) == tbl_src[k] &&
                        (r.dst & digit_mask(tbl_dwild[k])) == tbl_dst[k]) begin
                        v.matched   = 1'b1;
                        v.permitted = tbl_allow[k];
                        v.index     = 6'(k);
                        n_hit++;
                        break;
                    end
                end
            end
            REQ_CLEAR: rule_cnt = 0;
            default: n_spare++;
        endcase
        verdict_q.insert(verdict_q.size(), v);
    endtask

    task automatic cmp_field(input string name, input logic [7:0] got,
                             input logic [7:0] want);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            n_err++;
        end
    endtask

    task automatic check_verdict(input logic [OUT_DATA_W-1:0] d);
        t_verdict want;
        if (verdict_q.size() == 0) begin
            $display("%0t ns: unexpected result beat, expected none, got %h", $time, d);
            n_err++;
        end else begin
            want = verdict_q.pop_front();
            cmp_field("permitted",   8'(d[0]),   8'(want.permitted));
            cmp_field("matched",     8'(d[1]),   8'(want.matched));
            cmp_field("match_index", 8'(d[7:2]), 8'(want.index));
            cmp_field("status",      8'(d[8]),   8'(want.status));
        end
    endtask

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && !beat_taken)) begin
        end else if (pend_q.size() != 0 && !(pend_q[0].drain && verdict_q.size() != 0)
                     && $urandom_range(99) >= pend_q[0].idle_pct) begin
            on_bus = pend_q.pop_front();
            i_s_axis_tvalid <= 1'b1;
            i_s_axis_tuser  <= on_bus.kind;
            i_s_axis_tdata  <= {7'd0, on_bus.allow, on_bus.dwild, on_bus.dst,
                                on_bus.swild, on_bus.src};
            rx_stall_pct    <= on_bus.stall_pct;
        end else begin
            i_s_axis_tvalid <= 1'b0;
        end
    end

    always @(negedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            beat_taken <= 1'b0;
        end else begin
            beat_taken <= i_s_axis_tvalid && o_s_axis_tready;
            if (o_m_axis_tvalid && i_m_axis_tready) check_verdict(o_m_axis_tdata);
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                predict_verdict(on_bus);
                n_taken++;
            end
        end
    end

    function automatic logic [3:0] rand_digit();
        int r;
        r = $urandom_range(99);
        if (r < 50) return 4'($urandom_range(3));
        else if (r < 90) return 4'($urandom_range(9, 4));
        else return 4'($urandom_range(15, 10));
    endfunction

    function automatic logic [ADDR_W-1:0] rand_addr();
        logic [ADDR_W-1:0] a;
        if ($urandom_range(99) < 15) return $urandom;
        for (int d = 0; d < WILD_W; d++) a[d*DIG_W +: DIG_W] = rand_digit();
        return a;
    endfunction

    function automatic logic [WILD_W-1:0] rand_wild();
        int r;
        r = $urandom_range(99);
        if (r < 30) return '0;
        else if (r < 45) return '1;
        else if (r < 70) return WILD_W'(1) << $urandom_range(WILD_W - 1);
        else return WILD_W'($urandom);
    endfunction

    // address that meets a rule: wildcard digits filled at random, sometimes one bit off
    function automatic logic [ADDR_W-1:0] aim_addr(input logic [ADDR_W-1:0] a,
                                                  input logic [WILD_W-1:0] wild);
        logic [ADDR_W-1:0] r;
        r = a;
        for (int d = 0; d < WILD_W; d++) begin
            if (wild[d]) r[d*DIG_W +: DIG_W] = rand_digit();
        end
        if ($urandom_range(99) < 12) r[$urandom_range(ADDR_W - 1)] ^= 1'b1;
        return r;
    endfunction

    task automatic add_req(input logic [REQ_W-1:0] kind, input logic [ADDR_W-1:0] src,
                           input logic [WILD_W-1:0] sw, input logic [ADDR_W-1:0] dst,
                           input logic [WILD_W-1:0] dw, input logic allow);
        t_req r;
        r.kind  = kind;
        r.src   = src;
        r.swild = sw;
        r.dst   = dst;
        r.dwild = dw;
        r.allow = allow;
        case ((pend_q.size() / 80) % 4)
            0: begin r.idle_pct = 0;  r.stall_pct = 0;  end
            1: begin r.idle_pct = 85; r.stall_pct = 0;  end
            2: begin r.idle_pct = 0;  r.stall_pct = 85; end
            default: begin r.idle_pct = 20; r.stall_pct = 20; end
        endcase
        r.drain    = drain_next;
        drain_next = 0;
        pend_q.insert(pend_q.size(), r);
        if (kind == REQ_APPEND && gen_cnt < MAX_RULES) begin
            gen_src[gen_cnt]   = src;
            gen_swild[gen_cnt] = sw;
            gen_dst[gen_cnt]   = dst;
            gen_dwild[gen_cnt] = dw;
            gen_cnt++;
        end else if (kind == REQ_CLEAR) begin
            gen_cnt = 0;
        end
    endtask

    task automatic add_noise(input logic [REQ_W-1:0] kind);
        add_req(kind, $urandom, WILD_W'($urandom), $urandom, WILD_W'($urandom),
                1'($urandom));
    endtask

    task automatic add_random_classify();
        int k;
        if (gen_cnt != 0 && $urandom_range(99) < 70) begin
            k = ($urandom_range(99) < 40) ? gen_cnt - 1 : $urandom_range(gen_cnt - 1);
            add_req(REQ_CLASSIFY, aim_addr(gen_src[k], gen_swild[k]), WILD_W'($urandom),
                    aim_addr(gen_dst[k], gen_dwild[k]), WILD_W'($urandom), 1'($urandom));
        end else begin
            add_req(REQ_CLASSIFY, rand_addr(), WILD_W'($urandom), rand_addr(),
                    WILD_W'($urandom), 1'($urandom));
        end
    endtask

    initial begin
        int  n_app;
        int  n_cls;
        int  r;
        bit  first;

        // directed
        add_req(REQ_CLASSIFY, 32'h0000_0000, 8'h00, 32'h0000_0000, 8'h00, 1'b0);
        add_req(REQ_UNUSED,   32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 1'b1);
        add_req(REQ_APPEND,   32'h1234_5678, 8'hFF, 32'h8765_4321, 8'hFF, 1'b1);
        add_req(REQ_CLASSIFY, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 8'hFF, 1'b1);
        add_req(REQ_APPEND,   32'hFFFF_FFFF, 8'h00, 32'hFFFF_FFFF, 8'h00, 1'b0);
        add_req(REQ_CLASSIFY, 32'hFFFF_FFFF, 8'h00, 32'hFFFF_FFFF, 8'h00, 1'b0);
        add_req(REQ_CLASSIFY, 32'hFFFF_FFFE, 8'h00, 32'hFFFF_FFFF, 8'h00, 1'b0);
        add_req(REQ_APPEND,   32'h1234_5678, 8'h0F, 32'h8765_4321, 8'hF0, 1'b1);
        add_req(REQ_CLASSIFY, 32'h1234_ABCD, 8'h00, 32'hABCD_4321, 8'h00, 1'b0);
        add_req(REQ_CLASSIFY, 32'h1235_5678, 8'h00, 32'h8765_4321, 8'h00, 1'b0);
        add_req(REQ_APPEND,   32'h0000_0000, 8'h00, 32'h0000_0000, 8'h00, 1'b0);
        add_req(REQ_CLASSIFY, 32'h0000_0000, 8'h00, 32'h0000_0000, 8'h00, 1'b0);
        add_req(REQ_APPEND,   32'h9999_9999, 8'h01, 32'h0000_0000, 8'h80, 1'b1);
        add_req(REQ_CLASSIFY, 32'h9999_9990, 8'h00, 32'h5000_0000, 8'h00, 1'b0);
        add_req(REQ_UNUSED,   32'h0000_0000, 8'h00, 32'h0000_0000, 8'h00, 1'b0);
        add_req(REQ_CLASSIFY, 32'h9999_999F, 8'h00, 32'hF000_0000, 8'h00, 1'b0);
        add_req(REQ_CLEAR,    32'h0000_0000, 8'h00, 32'h0000_0000, 8'h00, 1'b0);
        add_req(REQ_CLASSIFY, 32'hFFFF_FFFF, 8'h00, 32'hFFFF_FFFF, 8'h00, 1'b1);
        add_req(REQ_APPEND,   32'h5555_5555, 8'hFF, 32'hAAAA_AAAA, 8'hFF, 1'b0);
        add_req(REQ_CLASSIFY, 32'h2468_1357, 8'hFF, 32'h1357_2468, 8'hFF, 1'b1);

        // random rule sets; the first one appends 60 to 70 rules, around the table size
        drain_next = 1;
        first      = 1;
        while (pend_q.size() < N_ITEMS) begin
            if (first || $urandom_range(99) < 85) add_noise(REQ_CLEAR);
            n_app = (first || $urandom_range(99) < 10) ? $urandom_range(70, 60)
                                                       : $urandom_range(12, 1);
            n_cls = $urandom_range(20, 3);
            first = 0;
            while (n_app + n_cls > 0) begin
                r = $urandom_range(99);
                if (r < 3) begin
                    add_noise(REQ_UNUSED);
                end else if (r < 4) begin
                    add_noise(REQ_CLEAR);
                end else if (n_app > 0 && (n_cls == 0 || r < 45)) begin
                    add_req(REQ_APPEND, rand_addr(), rand_wild(), rand_addr(), rand_wild(),
                            1'($urandom));
                    n_app--;
                end else begin
                    add_random_classify();
                    n_cls--;
                end
            end
            if ($urandom_range(99) < 5) drain_next = 1;
        end
        n_items = pend_q.size();

        while (!(n_taken == n_items && verdict_q.size() == 0)) @(posedge i_clk);
        repeat (TAIL_CYC) @(posedge i_clk);

        $display("%0d request beats: %0d classify (%0d hit a rule), %0d appends refused",
                 n_taken, n_class, n_hit, n_full);
        $display("%0d spare-code beats, %0d mismatches", n_spare, n_err);
        if (n_err == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
